@@ rtl/pfeq_pkg.sv @@
// pfeq_pkg: shared types and constants for the pinned fifo eviction queue
// used by the channel interfaces and the top level
`default_nettype none

package pfeq_pkg;

  localparam int ID_BITS = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int PIN_SLOTS_DEF = 4;
  localparam int SLOT_BITS = 2;
  localparam int COUNT_BITS = 4;

  typedef enum logic [1:0] {
    REQ_SAVE = 2'd0,
    REQ_UNSAVE = 2'd1,
    REQ_SET_PIN = 2'd2,
    REQ_READ_PIN = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OCCUPIED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PIN_SCAN,
    S_Q_RD,
    S_Q_CMP,
    S_EV_RD,
    S_EV_CAP,
    S_SH_RD,
    S_SH_WR,
    S_APPEND,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/pfeq_if.sv @@
// pfeq_in_if and pfeq_out_if: valid/ready channels carrying request and result words
// depends on pfeq_pkg
`default_nettype none

interface pfeq_in_if
  import pfeq_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ID_BITS-1:0]   family_id;
  logic [SLOT_BITS-1:0] generic_slot;
  logic                 ref_zero;

  modport source (output valid, req_type, family_id, generic_slot, ref_zero, input ready);
  modport sink (input valid, req_type, family_id, generic_slot, ref_zero, output ready);
endinterface

interface pfeq_out_if
  import pfeq_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  evicted_valid;
  logic [ID_BITS-1:0]    evicted_id;
  logic [ID_BITS-1:0]    slot_id;
  logic [COUNT_BITS-1:0] queue_count;

  modport source (output valid, status, evicted_valid, evicted_id, slot_id, queue_count,
                  input ready);
  modport sink (input valid, status, evicted_valid, evicted_id, slot_id, queue_count,
                output ready);
endinterface

`default_nettype wire

@@ rtl/pfeq_ram.sv @@
// pfeq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pfeq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/pinned_fifo_eviction_queue.sv @@
// pinned_fifo_eviction_queue: bounded fifo of eviction candidates plus pinned slots
// depends on pfeq_pkg, pfeq_if (channels) and pfeq_ram (queue storage)
//
// One request word is taken at a time and answered by exactly one result word. The queue
// lives in a ram with one read and one write port; a single comparator walks the pinned
// slots one per cycle and each queue entry in a read and a compare state, because of the
// registered ram read, and the same ram ports move entries one place forward when an id is
// removed or the oldest one is evicted. A save scans the pinned slots and, when the queue is
// full, evicts the oldest entry before it appends; a set also takes the id out of the queue
// when it is queued; an unsave searches the queue and scans the pinned slots when the id is
// not queued. A finished result sits in an output register, so the next request is taken
// while it waits. The queue ram needs no clearing after reset.
`default_nettype none

module pinned_fifo_eviction_queue
  import pfeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PIN_SLOTS = PIN_SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  pfeq_in_if.sink   in_chan,
  pfeq_out_if.source out_chan
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
  localparam int SXW = PW + SLOT_BITS;

  state_t state_r, state_nxt;

  logic [1:0]           req_r, req_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic                 refz_r, refz_nxt;
  logic [LW-1:0]        idx_r, idx_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [PW-1:0]        pidx_r, pidx_nxt;
  logic                 pin_wr_r, pin_wr_nxt;
  status_t              status_r, status_nxt;
  logic                 evv_r, evv_nxt;
  logic [ID_BITS-1:0]   evid_r, evid_nxt;
  logic [ID_BITS-1:0]   sval_r, sval_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r;
  logic                  out_evv_r;
  logic [ID_BITS-1:0]    out_evid_r;
  logic [ID_BITS-1:0]    out_sval_r;
  logic [COUNT_BITS-1:0] out_cnt_r;

  logic [ID_BITS-1:0] pins_r [PIN_SLOTS];

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic [SXW-1:0]     slot_ext;
  logic               slot_ok;
  logic [PW-1:0]      pin_addr;
  logic [ID_BITS-1:0] pin_rd;
  logic               pin_hit;
  logic               pin_last;
  logic               out_load;
  logic               accept;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // single pinned-slot read port
  assign slot_ext = SXW'(slot_r);
  assign slot_ok = (slot_ext < SXW'(PIN_SLOTS));
  assign pin_addr = (state_r == S_PIN_SCAN) ? pidx_r : slot_ext[PW-1:0];
  assign pin_rd = (32'(pin_addr) < 32'(PIN_SLOTS)) ? pins_r[pin_addr] : '0;
  assign pin_hit = (pin_rd == id_r);
  assign pin_last = (32'(pidx_r) == 32'(PIN_SLOTS - 1));
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_chan.ready);

  pfeq_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (req_r)
          REQ_SAVE: state_nxt = (id_r == '0) ? S_FINISH : S_PIN_SCAN;
          REQ_UNSAVE: state_nxt = (id_r == '0) ? S_FINISH : S_Q_RD;
          REQ_SET_PIN: begin
            if (id_r == '0 || !slot_ok || pin_rd != '0 || !refz_r) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_Q_RD;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_PIN_SCAN: begin
        if (pin_hit || pin_last) begin
          if (req_r != REQ_SAVE || pin_hit) begin
            state_nxt = S_FINISH;
          end else if (len_r >= LW'(QUEUE_DEPTH)) begin
            state_nxt = S_EV_RD;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_Q_RD: state_nxt = (idx_r >= len_r) ? S_PIN_SCAN : S_Q_CMP;
      S_Q_CMP: state_nxt = (ram_rdata == id_r) ? S_SH_RD : S_Q_RD;
      S_EV_RD: state_nxt = S_EV_CAP;
      S_EV_CAP: state_nxt = S_SH_RD;
      S_SH_RD: begin
        if (idx_r + LW'(1) < len_r) begin
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = (req_r == REQ_SAVE) ? S_APPEND : S_FINISH;
        end
      end
      S_SH_WR: state_nxt = S_SH_RD;
      S_APPEND: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_nxt = req_r;
    id_nxt = id_r;
    slot_nxt = slot_r;
    refz_nxt = refz_r;
    idx_nxt = idx_r;
    len_nxt = len_r;
    pidx_nxt = pidx_r;
    pin_wr_nxt = pin_wr_r;
    status_nxt = status_r;
    evv_nxt = evv_r;
    evid_nxt = evid_r;
    sval_nxt = sval_r;
    ram_we = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_chan.req_type;
          id_nxt = in_chan.family_id;
          slot_nxt = in_chan.generic_slot;
          refz_nxt = in_chan.ref_zero;
          idx_nxt = '0;
          pidx_nxt = '0;
          pin_wr_nxt = 1'b0;
          status_nxt = ST_OK;
          evv_nxt = 1'b0;
          evid_nxt = '0;
          sval_nxt = '0;
        end
      end
      S_DECODE: begin
        if (req_r == REQ_SET_PIN && id_r != '0 && slot_ok) begin
          if (pin_rd != '0) begin
            status_nxt = ST_OCCUPIED;
          end else begin
            pin_wr_nxt = 1'b1;
          end
        end
        if (req_r == REQ_READ_PIN && slot_ok) begin
          sval_nxt = pin_rd;
        end
      end
      S_PIN_SCAN: begin
        pidx_nxt = pidx_r + PW'(1);
        if ((pin_hit || pin_last) && req_r != REQ_SAVE) begin
          status_nxt = pin_hit ? ST_OK : ST_NOT_FOUND;
        end
      end
      S_Q_CMP: begin
        if (ram_rdata != id_r) begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      S_EV_RD: begin
        ram_raddr = '0;
        idx_nxt = '0;
      end
      S_EV_CAP: begin
        evv_nxt = 1'b1;
        evid_nxt = ram_rdata;
      end
      S_SH_RD: begin
        ram_raddr = AW'(idx_r + LW'(1));
        if (idx_r + LW'(1) >= len_r) begin
          len_nxt = len_r - LW'(1);
        end
      end
      S_SH_WR: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt = idx_r + LW'(1);
      end
      S_APPEND: begin
        ram_we = 1'b1;
        ram_waddr = len_r[AW-1:0];
        ram_wdata = id_r;
        len_nxt = len_r + LW'(1);
      end
      S_FINISH: begin
        if (out_load) begin
          pin_wr_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PIN_SLOTS; i++) begin
        pins_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load && pin_wr_r) begin
        pins_r[slot_ext[PW-1:0]] <= id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    id_r <= id_nxt;
    slot_r <= slot_nxt;
    refz_r <= refz_nxt;
    idx_r <= idx_nxt;
    pidx_r <= pidx_nxt;
    pin_wr_r <= pin_wr_nxt;
    status_r <= status_nxt;
    evv_r <= evv_nxt;
    evid_r <= evid_nxt;
    sval_r <= sval_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_evv_r <= evv_r;
      out_evid_r <= evid_r;
      out_sval_r <= sval_r;
      out_cnt_r <= COUNT_BITS'(len_r);
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.evicted_valid = out_evv_r;
  assign out_chan.evicted_id = out_evid_r;
  assign out_chan.slot_id = out_sval_r;
  assign out_chan.queue_count = out_cnt_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evv_r |-> out_cnt_r == COUNT_BITS'(QUEUE_DEPTH))
    else $error("eviction reported while queue not full");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_WR |-> idx_r < len_r)
    else $error("shift beyond queue length");

  a_one_pin_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && pin_wr_r |=> state_r == S_IDLE && !pin_wr_r)
    else $error("pinned slot write not single");

endmodule

`default_nettype wire
